// File: src/apq_pkg.sv
package apq_pkg;

    localparam int TAG_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int AGE_W    = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int ENTRY_W  = TAG_W + PRIO_W + AGE_W;

    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_MAX      = 8'hFF;
    localparam logic [AGE_W-1:0]  AGE_MAX       = 8'hFF;
    localparam logic [7:0]        THRESHOLD_RST = 8'd5;

    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [AGE_W-1:0]  age;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_TICK,
        S_FIN
    } t_state;

endpackage

// File: src/apq_in_if.sv
interface apq_in_if import apq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    entry_tag;
    logic [PRIO_W-1:0]   new_priority;

    modport source (output valid, kind, entry_tag, new_priority, input ready);
    modport sink   (input valid, kind, entry_tag, new_priority, output ready);
endinterface

// File: src/apq_out_if.sv
interface apq_out_if import apq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    served_tag;
    logic [PRIO_W-1:0]   served_priority;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, served_tag, served_priority, occupancy,
                    input ready);
    modport sink   (input valid, status, served_tag, served_priority, occupancy,
                    output ready);
endinterface

// File: src/apq_ram.sv
module apq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/aging_priority_queue_top.sv
// Walk: an enqueue visits every held entry and then the free slot; dequeue and
//   aging tick visit every held entry; items that touch no entry go straight to finish.
// Throughput: one item at a time; the entry RAM walk (one entry per cycle
//   through a single write port and a single registered read port) sets it.
// Reset: synchronous, active low; clears the entry count, the pending result
//   and sets aging_threshold to 5. The entry RAM is not cleared.
module aging_priority_queue_top import apq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    apq_in_if.sink       i_req,
    apq_out_if.source    o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Sequencer and item latch
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_ins, n_ins;
    t_entry              r_carry, n_carry;
    logic [KIND_W-1:0]   r_kind;
    logic [TAG_W-1:0]    r_tag;
    logic [PRIO_W-1:0]   r_prio;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [TAG_W-1:0]    r_srv_tag, n_srv_tag;
    logic [PRIO_W-1:0]   r_srv_prio, n_srv_prio;
    logic [7:0]          r_thr;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TAG_W-1:0]    r_out_tag;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [OCC_W-1:0]    r_out_occ;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic                accept;
    logic                out_free;
    logic                load_out;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       last_idx;
    t_entry              rd_entry;
    t_entry              new_entry;
    t_entry              aged;
    logic [AGE_W-1:0]    age_up;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign idx_inc   = r_idx + 1'b1;
    assign idx_dec   = r_idx - 1'b1;
    assign last_idx  = r_count - 1'b1;
    assign rd_entry  = t_entry'(ram_rdata);
    assign new_entry = '{tag: r_tag, prio: r_prio, age: '0};

    // Age saturates first, then the priority bump looks at the new age.
    assign age_up    = (rd_entry.age == AGE_MAX) ? rd_entry.age : rd_entry.age + 1'b1;
    assign aged.tag  = rd_entry.tag;
    assign aged.age  = age_up;
    assign aged.prio = (age_up > r_thr && rd_entry.prio != PRIO_MAX) ?
                       rd_entry.prio + 1'b1 : rd_entry.prio;

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        KIND_ENQ:  n_state = (r_count != FULL_CNT) ? S_ENQ : S_FIN;
                        KIND_DEQ:  n_state = (r_count != '0) ? S_DEQ : S_FIN;
                        KIND_TICK: n_state = (r_count != '0) ? S_TICK : S_FIN;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_ENQ: begin
                if (r_idx == r_count) n_state = S_FIN;
            end
            S_DEQ, S_TICK: begin
                if (r_idx == last_idx) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and RAM control. In each walk state the data of entry r_idx
    // arrives from the RAM while the read of entry r_idx+1 is issued, so the
    // write (always at r_idx or r_idx-1) never hits the entry being read.
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        ram_raddr   = (r_state == S_IDLE) ? '0 : idx_inc[AW-1:0];
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = new_entry;
        load_out    = 1'b0;
        n_count     = r_count;
        n_idx       = idx_inc;
        n_ins       = r_ins;
        n_carry     = r_carry;
        n_status    = r_status;
        n_srv_tag   = r_srv_tag;
        n_srv_prio  = r_srv_prio;
        n_out_valid = r_out_valid && !o_rsp.ready;
        case (r_state)
            S_IDLE: begin
                n_idx      = '0;
                n_ins      = 1'b0;
                n_srv_tag  = '0;
                n_srv_prio = '0;
                n_status   = ST_DONE;
                if (i_req.kind == KIND_ENQ && r_count == FULL_CNT) n_status = ST_FULL;
                if (i_req.kind == KIND_DEQ && r_count == '0)       n_status = ST_EMPTY;
            end
            S_ENQ: begin
                // Walk until the first lower-priority entry, then ripple the
                // displaced entries one place toward the tail.
                if (r_idx == r_count) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_ins ? r_carry : new_entry;
                    n_count   = r_count + 1'b1;
                end else if (r_ins || rd_entry.prio < r_prio) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_ins ? r_carry : new_entry;
                    n_carry   = rd_entry;
                    n_ins     = 1'b1;
                end
            end
            S_DEQ: begin
                if (r_idx == '0) begin
                    n_srv_tag  = rd_entry.tag;
                    n_srv_prio = rd_entry.prio;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[AW-1:0];
                    ram_wdata = rd_entry;
                end
                if (r_idx == last_idx) n_count = r_count - 1'b1;
            end
            S_TICK: begin
                ram_we    = 1'b1;
                ram_wdata = aged;
            end
            S_FIN: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THRESHOLD_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && paddr[2] == REG_THRESHOLD) begin
                r_thr <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_ins      <= n_ins;
        r_carry    <= n_carry;
        r_status   <= n_status;
        r_srv_tag  <= n_srv_tag;
        r_srv_prio <= n_srv_prio;
        if (accept) begin
            r_kind <= i_req.kind;
            r_tag  <= i_req.entry_tag;
            r_prio <= i_req.new_priority;
        end
        if (load_out) begin
            r_out_status <= r_status;
            r_out_tag    <= r_srv_tag;
            r_out_prio   <= r_srv_prio;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.served_tag      = r_out_tag;
    assign o_rsp.served_priority = r_out_prio;
    assign o_rsp.occupancy       = r_out_occ;

    assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'b0, r_thr} : 32'b0;
    assign pready = 1'b1;

    // Count never runs past the RAM depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond depth");

    // The RAM is written only by the walk states.
    a_we_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_ENQ || r_state == S_DEQ || r_state == S_TICK))
        else $error("RAM write outside a walk");

    // An accepted item always leaves idle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted item did not start");

    // A new result appears only from the finish step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish");

    // Count moves only at the end of a walk, by one entry.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != n_count) |-> (n_state == S_FIN &&
            (r_kind == KIND_ENQ || r_kind == KIND_DEQ)))
        else $error("count changed mid-walk");

endmodule
